// ===== hdl/dipp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipp_pkg
// Types and character constants shared by the dotted pair parser modules.
// ----------------------------------------------------------------------------
package dipp_pkg;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEAD,
        PH_FIRST,
        PH_DOT,
        PH_MINUS,
        PH_SECOND
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] first_accum;
        logic [31:0] second_accum;
        logic        first_is_negative;
        logic        second_is_negative;
        logic        first_digits_seen;
    } parse_state_t;

    typedef struct packed {
        logic        is_valid;
        logic [31:0] first_number;
        logic [31:0] second_number;
        logic [7:0]  stop_position;
    } parse_result_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [35:0] FIRST_LIMIT  = 36'h0_8000_0000;
    localparam logic [35:0] SECOND_LIMIT = 36'h0_7FFF_FFFF;
    localparam logic [31:0] FIRST_CLAMP  = 32'h7FFF_FFFF;
    localparam logic [31:0] NUM_NONE     = 32'hFFFF_FFFF;

    localparam parse_state_t STATE_RESET = '{
        phase:              PH_DONE,
        first_accum:        32'd0,
        second_accum:       32'd0,
        first_is_negative:  1'b0,
        second_is_negative: 1'b0,
        first_digits_seen:  1'b0
    };

endpackage

// ===== hdl/dipp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipp_step
// Next-state and result logic for one text character of the pair parser.
// ----------------------------------------------------------------------------
module dipp_step #(
    parameter int MAX_POSITION = 255,
    parameter int POS_W        = 8
) (
    input  logic                   start_of_text,
    input  logic [7:0]             char_code,
    input  dipp_pkg::parse_state_t state,
    input  logic [POS_W-1:0]       position,
    output dipp_pkg::parse_state_t state_next,
    output logic [POS_W-1:0]       position_next,
    output logic                   emit,
    output dipp_pkg::parse_result_t result
);
    import dipp_pkg::*;

    localparam logic [POS_W:0] MAX_POS_EXT = (POS_W+1)'(MAX_POSITION);

    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] pos,
                                                 input logic [1:0] by);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + (POS_W+1)'(by);
        return (sum > MAX_POS_EXT) ? MAX_POS_EXT[POS_W-1:0] : sum[POS_W-1:0];
    endfunction

    parse_state_t     cur;
    logic [POS_W-1:0] pos;
    logic             is_digit;
    logic             is_ws;
    logic             is_end;
    logic             is_end_comma;
    logic             use_second;
    logic [31:0]      acc_in;
    logic [35:0]      acc_wide;
    logic [35:0]      product;
    logic [35:0]      limit;
    logic [31:0]      acc_sat;
    logic [31:0]      first_val;
    logic [31:0]      second_val;
    logic             first_nonneg;
    logic             ok;
    logic [31:0]      val_a;
    logic [31:0]      val_b;
    logic [POS_W-1:0] stop;

    always_comb
    begin
        // A start flag restarts the parse on this very character.
        cur       = state;
        pos       = position;
        if (start_of_text)
        begin
            cur       = STATE_RESET;
            cur.phase = PH_LEAD;
            pos       = '0;
        end

        is_digit     = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_ws        = (char_code == CH_SPACE) ||
                       ((char_code >= CH_TAB) && (char_code <= CH_CR));
        is_end       = (char_code == CH_NUL) || is_ws;
        is_end_comma = is_end || (char_code == CH_COMMA);

        // One shared multiply-by-ten accumulator serves both numbers.
        use_second = (cur.phase == PH_DOT) || (cur.phase == PH_MINUS) ||
                     (cur.phase == PH_SECOND);
        acc_in   = use_second ? cur.second_accum : cur.first_accum;
        acc_wide = 36'(acc_in);
        product  = (acc_wide << 3) + (acc_wide << 1) + 36'(char_code - CH_ZERO);
        limit    = use_second ? SECOND_LIMIT : FIRST_LIMIT;
        acc_sat  = (product > limit) ? limit[31:0] : product[31:0];

        if (cur.first_is_negative)
            first_val = 32'd0 - cur.first_accum;
        else
            first_val = cur.first_accum[31] ? FIRST_CLAMP : cur.first_accum;
        first_nonneg = !cur.first_is_negative || (cur.first_accum == 32'd0);
        second_val   = cur.second_is_negative ? (32'd0 - cur.second_accum)
                                              : cur.second_accum;

        state_next    = cur;
        position_next = pos_add(pos, 2'd1);
        emit          = 1'b0;
        ok            = 1'b0;
        val_a         = NUM_NONE;
        val_b         = NUM_NONE;
        stop          = pos;

        unique case (cur.phase)
            PH_LEAD:
            begin
                if (is_ws)
                begin
                end
                else if ((char_code == CH_PLUS) || (char_code == CH_MINUS))
                begin
                    state_next.first_is_negative = (char_code == CH_MINUS);
                    state_next.phase             = PH_FIRST;
                end
                else if (is_digit)
                begin
                    state_next.first_accum       = acc_sat;
                    state_next.first_digits_seen = 1'b1;
                    state_next.phase             = PH_FIRST;
                end
                else if ((char_code == CH_DOT) && (pos == '0))
                begin
                    // A leading dot reads as first number zero.
                    state_next.phase = PH_DOT;
                end
                else
                begin
                    emit = 1'b1;
                    stop = '0;
                end
            end
            PH_FIRST:
            begin
                if (is_digit)
                begin
                    state_next.first_accum       = acc_sat;
                    state_next.first_digits_seen = 1'b1;
                end
                else if (!cur.first_digits_seen)
                begin
                    emit = 1'b1;
                    stop = '0;
                end
                else if (is_end_comma)
                begin
                    emit  = 1'b1;
                    ok    = first_nonneg;
                    val_a = first_val;
                end
                else if (char_code == CH_DOT)
                begin
                    state_next.phase = PH_DOT;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_DOT:
            begin
                if (is_end_comma)
                begin
                    emit  = 1'b1;
                    ok    = first_nonneg;
                    val_a = first_val;
                end
                else if (char_code == CH_MINUS)
                begin
                    // The position stays on the character after the dot.
                    state_next.second_is_negative = 1'b1;
                    state_next.phase              = PH_MINUS;
                    position_next                 = pos;
                end
                else if (!is_digit)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    state_next.second_accum = acc_sat;
                    state_next.phase        = PH_SECOND;
                end
            end
            PH_MINUS:
            begin
                if (!is_digit)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    state_next.second_accum = acc_sat;
                    state_next.phase        = PH_SECOND;
                    position_next           = pos_add(pos, 2'd2);
                end
            end
            PH_SECOND:
            begin
                if (is_digit)
                begin
                    state_next.second_accum = acc_sat;
                end
                else
                begin
                    emit  = 1'b1;
                    ok    = is_end;
                    val_a = first_val;
                    val_b = second_val;
                end
            end
            default:
            begin
                // No parse open: the character is dropped.
                position_next = pos;
            end
        endcase

        if (emit)
        begin
            state_next.phase = PH_DONE;
            position_next    = pos;
        end

        result.is_valid      = ok;
        result.first_number  = ok ? val_a : NUM_NONE;
        result.second_number = ok ? val_b : NUM_NONE;
        result.stop_position = 8'(stop);
    end

endmodule

// ===== hdl/dotted_id_pair_parser.sv =====
`timescale 1ns / 1ps
// A character that decides the parse is held in the input register; its result
// goes to the output register on m_axis_tvalid (two register stages).
// Throughput: one character per cycle; the input side stalls only when a
// deciding character meets a full output register that is not being taken.
// Reset: asynchronous, clears the valid flags and the parse state, and leaves
// the parser idle until a character with the start flag arrives.
// ----------------------------------------------------------------------------
// dotted_id_pair_parser
// Streaming parser for number pairs such as 12.3, one character per request.
// ----------------------------------------------------------------------------
module dotted_id_pair_parser #(
    parameter int MAX_POSITION = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,  // [0] start_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [31:0] first_number, [63:32] second_number,
                                       // [71:64] stop_position
    output logic [0:0]  m_axis_tuser   // [0] is_valid
);
    import dipp_pkg::*;

    localparam int POS_W = $clog2(MAX_POSITION + 1);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic             in_start_reg;
    logic [7:0]       in_char_reg;
    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    parse_result_t    out_result_reg;
    parse_result_t    step_result;
    logic             step_emit;
    logic             in_advance;

    dipp_step #(
        .MAX_POSITION (MAX_POSITION),
        .POS_W        (POS_W)
    ) u_step (
        .start_of_text (in_start_reg),
        .char_code     (in_char_reg),
        .state         (state_reg),
        .position      (pos_reg),
        .state_next    (state_next),
        .position_next (pos_next),
        .emit          (step_emit),
        .result        (step_result)
    );

    // The held character moves on unless it would overwrite a waiting result.
    assign in_advance    = in_valid_reg && (!step_emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;

        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (in_advance && step_emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            pos_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_advance)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_start_reg <= s_axis_tuser[0];
            in_char_reg  <= s_axis_tdata;
        end
        if (in_advance && step_emit)
            out_result_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.is_valid;
    assign m_axis_tdata  = {out_result_reg.stop_position,
                            out_result_reg.second_number,
                            out_result_reg.first_number};

`ifndef ASSERT_OFF
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_advance && step_emit))
        else $error("result appeared without a deciding character");

    a_invalid_is_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (out_result_reg.first_number == NUM_NONE &&
         out_result_reg.second_number == NUM_NONE))
        else $error("invalid result carries numbers");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} <= (POS_W+1)'(MAX_POSITION)))
        else $error("character position beyond its limit");

    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_advance && step_emit) |=> (state_reg.phase == PH_DONE))
        else $error("parse still open after its result");
`endif

endmodule

// ===== sim/dipp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipp_checker
// Watches both stream sides of the dotted pair parser. It predicts the results
// from every accepted character and compares each accepted result, field by
// field, with the oldest expected one.
// ----------------------------------------------------------------------------
module dipp_checker #(
    parameter int MAX_POSITION = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,  // [0] start_of_text
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,  // [31:0] first_number, [63:32] second_number,
                                       // [71:64] stop_position
    input  logic [0:0]  m_axis_tuser,  // [0] is_valid
    output int          errors,
    output int          pending
);
    import dipp_pkg::*;

    parse_result_t pair_q[$];
    parse_result_t seen;

    phase_t        ph;
    logic [31:0]   first_acc;
    logic [31:0]   second_acc;
    bit            first_neg;
    bit            second_neg;
    bit            first_seen;
    int unsigned   char_pos;

    function automatic bit is_space(logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic logic [31:0] mul10_add(logic [31:0] acc, logic [7:0] ch,
                                              logic [35:0] cap);
        logic [63:0] v;
        v = {32'd0, acc} * 64'd10 + {56'd0, ch - CH_ZERO};
        return (v > {28'd0, cap}) ? cap[31:0] : v[31:0];
    endfunction

    function automatic int unsigned advance(int unsigned at, int unsigned by);
        return (at + by > MAX_POSITION) ? MAX_POSITION : at + by;
    endfunction

    function automatic logic [31:0] first_result();
        if (first_neg)
            return 32'd0 - first_acc;
        return (first_acc > FIRST_CLAMP) ? FIRST_CLAMP : first_acc;
    endfunction

    function automatic bit first_nonneg();
        return !first_neg || first_acc == 32'd0;
    endfunction

    task automatic close_parse(bit ok, logic [31:0] a, logic [31:0] b, int unsigned stop);
        parse_result_t r;
        r.is_valid      = ok;
        r.first_number  = ok ? a : NUM_NONE;
        r.second_number = ok ? b : NUM_NONE;
        r.stop_position = stop[7:0];
        pair_q = {pair_q, r};
        ph = PH_DONE;
    endtask

    task automatic parse_char(bit sot, logic [7:0] ch);
        int unsigned at;
        bit          step_on;
        if (sot)
        begin
            ph         = PH_LEAD;
            first_acc  = '0;
            second_acc = '0;
            first_neg  = 1'b0;
            second_neg = 1'b0;
            first_seen = 1'b0;
            char_pos   = 0;
        end
        at      = char_pos;
        step_on = 1'b1;
        case (ph)
            PH_LEAD:
            begin
                if (!is_space(ch))
                begin
                    if (ch == CH_PLUS || ch == CH_MINUS)
                    begin
                        first_neg = (ch == CH_MINUS);
                        ph        = PH_FIRST;
                    end
                    else if (is_digit(ch))
                    begin
                        first_acc  = mul10_add(first_acc, ch, FIRST_LIMIT);
                        first_seen = 1'b1;
                        ph         = PH_FIRST;
                    end
                    else if (ch == CH_DOT && at == 0)
                    begin
                        // A dot at the very start stands for a first number of zero.
                        ph = PH_DOT;
                    end
                    else
                    begin
                        close_parse(1'b0, '0, '0, 0);
                        step_on = 1'b0;
                    end
                end
            end
            PH_FIRST:
            begin
                if (is_digit(ch))
                begin
                    first_acc  = mul10_add(first_acc, ch, FIRST_LIMIT);
                    first_seen = 1'b1;
                end
                else if (!first_seen)
                begin
                    close_parse(1'b0, '0, '0, 0);
                    step_on = 1'b0;
                end
                else if (ch == CH_NUL || is_space(ch) || ch == CH_COMMA)
                begin
                    close_parse(first_nonneg(), first_result(), NUM_NONE, at);
                    step_on = 1'b0;
                end
                else if (ch == CH_DOT)
                begin
                    ph = PH_DOT;
                end
                else
                begin
                    close_parse(1'b0, '0, '0, at);
                    step_on = 1'b0;
                end
            end
            PH_DOT:
            begin
                step_on = 1'b0;
                if (ch == CH_NUL || is_space(ch) || ch == CH_COMMA)
                begin
                    close_parse(first_nonneg(), first_result(), NUM_NONE, at);
                end
                else if (ch == CH_MINUS)
                begin
                    // The position stays on the character after the dot.
                    second_neg = 1'b1;
                    ph         = PH_MINUS;
                end
                else if (!is_digit(ch))
                begin
                    close_parse(1'b0, '0, '0, at);
                end
                else
                begin
                    second_acc = mul10_add(second_acc, ch, SECOND_LIMIT);
                    ph         = PH_SECOND;
                    step_on    = 1'b1;
                end
            end
            PH_MINUS:
            begin
                step_on = 1'b0;
                if (!is_digit(ch))
                begin
                    close_parse(1'b0, '0, '0, at);
                end
                else
                begin
                    second_acc = mul10_add(second_acc, ch, SECOND_LIMIT);
                    ph         = PH_SECOND;
                    char_pos   = advance(at, 2);
                end
            end
            PH_SECOND:
            begin
                if (is_digit(ch))
                begin
                    second_acc = mul10_add(second_acc, ch, SECOND_LIMIT);
                end
                else
                begin
                    close_parse(ch == CH_NUL || is_space(ch), first_result(),
                                second_neg ? 32'd0 - second_acc : second_acc, at);
                    step_on = 1'b0;
                end
            end
            default: step_on = 1'b0;
        endcase
        if (step_on)
            char_pos = advance(at, 1);
    endtask

    task automatic check_result(parse_result_t got);
        parse_result_t want;
        if (pair_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: valid %0d first %0d second %0d stop %0d",
                         got.is_valid, $signed(got.first_number),
                         $signed(got.second_number), got.stop_position);
        end
        else
        begin
            want = pair_q.pop_front();
            if (got.is_valid !== want.is_valid
                || got.first_number !== want.first_number
                || got.second_number !== want.second_number
                || got.stop_position !== want.stop_position)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("mismatch exp/act: valid %0d/%0d first %0d/%0d ",
                           want.is_valid, got.is_valid,
                           $signed(want.first_number), $signed(got.first_number));
                    $display("second %0d/%0d stop %0d/%0d",
                             $signed(want.second_number), $signed(got.second_number),
                             want.stop_position, got.stop_position);
                end
            end
        end
    endtask

    // Inputs are taken before outputs so that a character and a result on the
    // same edge are handled in stream order.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pair_q.delete();
            errors     = 0;
            pending    = 0;
            ph         = PH_DONE;
            first_acc  = '0;
            second_acc = '0;
            first_neg  = 1'b0;
            second_neg = 1'b0;
            first_seen = 1'b0;
            char_pos   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_char(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.is_valid      = m_axis_tuser[0];
                seen.first_number  = m_axis_tdata[31:0];
                seen.second_number = m_axis_tdata[63:32];
                seen.stop_position = m_axis_tdata[71:64];
                check_result(seen);
            end
            pending = pair_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the dotted pair parser with directed texts and then with random
// texts, mostly well formed, some corrupted and some pure noise, under random
// stalls on both sides. The checker module predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import dipp_pkg::*;

    localparam int MAX_POSITION   = 255;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int RX_HOLD_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int          fail_count;
    int          open_count;
    bit          steady;
    bit          hold_req;
    logic [7:0]  text_q[$];

    dotted_id_pair_parser #(
        .MAX_POSITION(MAX_POSITION)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    dipp_checker #(
        .MAX_POSITION(MAX_POSITION)
    ) pair_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .errors(fail_count),
        .pending(open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: ready in bursts, with random gaps and one long hold-off on demand.
    initial
    begin : result_sink
        int run_len;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(1, 24);
            repeat (run_len) @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if (!steady)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    task automatic send_char(input bit sot, input logic [7:0] ch);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= sot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!steady && $urandom_range(0, 99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic add_char(input logic [7:0] ch);
        text_q = {text_q, ch};
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(i == 0, text_q[i]);
    endtask

    task automatic play(input string body, input logic [7:0] tail);
        text_q.delete();
        for (int i = 0; i < body.len(); i++)
            add_char(body[i]);
        add_char(tail);
        send_text();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (open_count == 0);
    endtask

    function automatic logic [7:0] rand_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
    endfunction

    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 4);
        if (r < 95)
            return $urandom_range(5, 9);
        return $urandom_range(10, 12);
    endfunction

    task automatic push_digits(input int n);
        repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Builds one text into text_q. Characters that follow the deciding one
    // are appended at times but left out of the count.
    task automatic build_text(input bit long_lead, output int counted);
        int r;
        int n;
        bit lead_dot;
        text_q.delete();
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (long_lead)
                n = $urandom_range(240, 270);
            else
                n = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 3);
            repeat (n) add_char(rand_ws());
            lead_dot = (n == 0) && ($urandom_range(0, 9) == 0);
            if (lead_dot)
            begin
                add_char(CH_DOT);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:    add_char(CH_PLUS);
                    2, 3:    add_char(CH_MINUS);
                    default: ;
                endcase
                push_digits(digit_count());
            end
            if (lead_dot || $urandom_range(0, 9) < 6)
            begin
                if (!lead_dot)
                    add_char(CH_DOT);
                if ($urandom_range(0, 3) != 0)
                begin
                    if ($urandom_range(0, 9) < 3)
                        add_char(CH_MINUS);
                    if ($urandom_range(0, 9) != 0)
                        push_digits(digit_count());
                end
            end
            n = $urandom_range(0, 99);
            if (n < 35)
                add_char(CH_NUL);
            else if (n < 60)
                add_char(rand_ws());
            else if (n < 80)
                add_char(CH_COMMA);
            else if (n >= 90)
                add_char(8'($urandom_range(0, 255)));
            // Between 80 and 90 the text stays open and the next start abandons it.
            if (r < 27)
                text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        counted = text_q.size();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        int items;
        int texts;
        int counted;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A character before any start of text is ignored.
        send_char(1'b0, CH_ZERO + 8'd5);
        play("0", CH_NUL);
        play("-5", CH_SPACE);
        play("-0", CH_TAB);
        play(".5", CH_NUL);
        play("1.", CH_COMMA);
        play("-3.-4", CH_NUL);
        play(" .", CH_NUL);
        play("x", CH_NUL);
        play("+", CH_COMMA);
        play("", 8'hFF);
        drain();

        // Hold the result side while requests keep coming, so the input stalls.
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (30)
        begin
            build_text(1'b0, counted);
            send_text();
        end
        steady = 1'b0;
        drain();

        items = 0;
        texts = 0;
        while (items < RANDOM_ITEMS)
        begin
            if (texts % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            build_text(texts == 0 || $urandom_range(0, 99) == 0, counted);
            send_text();
            items += counted;
            texts++;
            if (texts % 150 == 0)
                drain();
        end
        steady = 1'b0;
        drain();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && open_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
